### hw/rtl/mvm_pkg.sv
// Shared types and constants for the mecanum velocity mixer.
// Used by mvm_seq, mvm_datapath and the top level; depends on nothing.
package mvm_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int DUTY_BITS_DEF = 10;
   localparam int VEL_W         = 16;
   localparam int CSR_IDX_W     = 2;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY     = 2'd2;

   localparam int DEADZONE_RST = 328;
   localparam int ALPHA_RST    = 13107;
   localparam int DUTY_RST     = 1023;

   // Last axis (forward, side, turn) and last wheel (FL, FR, RL, RR) indexes.
   localparam logic [1:0] AXIS_LAST  = 2'd2;
   localparam logic [1:0] WHEEL_LAST = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_FILT_NEW,
      ST_FILT_OLD,
      ST_MAX,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_FILT_NEW,
      OP_FILT_OLD,
      OP_MAX,
      OP_MUL,
      OP_DIV,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
      logic       last;
   } ctrl_type;

endpackage

### hw/rtl/mecanum_velocity_mixer.sv
// Mecanum velocity mixer top level. An accepted beat raises rsp_tvalid once
// filtering, peak search and division are done; an all-zero command clears the
// filter state instead of filtering. The time is set by the shared multiplier
// (six filter steps) and the radix-2 divider, one quotient bit a cycle per wheel.
// A finished beat waits in the output register while the next item is taken.
// Synchronous reset clears the filter state and loads the register defaults.
module mecanum_velocity_mixer
   import mvm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int DUTY_BITS = DUTY_BITS_DEF,
   localparam int CSR_W    = (FRAC_BITS + 1 > DUTY_BITS) ? FRAC_BITS + 1 : DUTY_BITS,
   localparam int RSP_W    = ((4 * (DUTY_BITS + 1) + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Fields from bit 0: forward_velocity, side_velocity, turn_velocity.
   input  logic [3*VEL_W-1:0]    req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: front_left_target, front_right_target,
   // rear_left_target, rear_right_target, then zero padding.
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int OW = DUTY_BITS + 1;

   logic [FRAC_BITS-1:0]  deadzone_ff;
   logic [FRAC_BITS:0]    alpha_ff;
   logic [DUTY_BITS-1:0]  duty_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  busy, start, all_zero, rsp_free;
   ctrl_type              ctrl;
   logic signed [OW-1:0]  fl_tgt, fr_tgt, rl_tgt, rr_tgt;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= FRAC_BITS'(DEADZONE_RST);
         alpha_ff    <= (FRAC_BITS + 1)'(ALPHA_RST);
         duty_ff     <= DUTY_BITS'(DUTY_RST);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEADZONE: deadzone_ff <= csr_wdata[FRAC_BITS-1:0];
            CSR_ALPHA:    alpha_ff    <= csr_wdata[FRAC_BITS:0];
            CSR_DUTY:     duty_ff     <= csr_wdata[DUTY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign all_zero   = (req_tdata == '0);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   mvm_seq #(
      .DUTY_BITS (DUTY_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .all_zero (all_zero),
      .rsp_free (rsp_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   mvm_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .DUTY_BITS (DUTY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .load               (start),
      .forward_velocity   (req_tdata[0 +: VEL_W]),
      .side_velocity      (req_tdata[VEL_W +: VEL_W]),
      .turn_velocity      (req_tdata[2*VEL_W +: VEL_W]),
      .deadzone_level     (deadzone_ff),
      .filter_alpha       (alpha_ff),
      .max_duty           (duty_ff),
      .front_left_target  (fl_tgt),
      .front_right_target (fr_tgt),
      .rear_left_target   (rl_tgt),
      .rear_right_target  (rr_tgt)
   );

   // Output register: loaded when the sequencer publishes, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.op == OP_PUBLISH) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({rr_tgt, rl_tgt, fr_tgt, fl_tgt});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/mvm_seq.sv
// Sequencer of the mecanum velocity mixer: steps the shared multiply and
// compare-subtract unit through filter, peak search and division. Uses mvm_pkg.
module mvm_seq
   import mvm_pkg::*;
#(
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     all_zero,
   input  logic     rsp_free,
   output logic     busy,
   output ctrl_type ctrl
);

   localparam int SW = $clog2(DUTY_BITS);

   state_type         state_ff, state_in;
   logic [1:0]        idx_ff, idx_in;
   logic [SW-1:0]     step_ff, step_in;
   logic              step_last;

   assign step_last = (step_ff == SW'(DUTY_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               state_in = all_zero ? ST_ZERO : ST_FILT_NEW;
            end
         end
         ST_ZERO: begin
            state_in = ST_MAX;
            idx_in   = '0;
         end
         ST_FILT_NEW: begin
            state_in = ST_FILT_OLD;
         end
         ST_FILT_OLD: begin
            if (idx_ff == AXIS_LAST) begin
               state_in = ST_MAX;
               idx_in   = '0;
            end else begin
               state_in = ST_FILT_NEW;
               idx_in   = idx_ff + 2'd1;
            end
         end
         ST_MAX: begin
            if (idx_ff == WHEEL_LAST) begin
               state_in = ST_MUL;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            if (step_last) begin
               if (idx_ff == WHEEL_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL;
                  idx_in   = idx_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.idx  = idx_ff;
      ctrl.last = step_last;
      busy      = (state_ff != ST_IDLE);
      case (state_ff)
         ST_ZERO:     ctrl.op = OP_CLEAR;
         ST_FILT_NEW: ctrl.op = OP_FILT_NEW;
         ST_FILT_OLD: ctrl.op = OP_FILT_OLD;
         ST_MAX:      ctrl.op = OP_MAX;
         ST_MUL:      ctrl.op = OP_MUL;
         ST_DIV:      ctrl.op = OP_DIV;
         ST_DONE:     ctrl.op = rsp_free ? OP_PUBLISH : OP_NONE;
         default:     ctrl.op = OP_NONE;
      endcase
   end

endmodule

### hw/rtl/mvm_datapath.sv
// Datapath of the mecanum velocity mixer: one signed multiplier with an adder,
// one compare-subtract stage, filter state and wheel targets. Uses mvm_pkg.
module mvm_datapath
   import mvm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_type                    ctrl,
   input  logic                        load,
   input  logic signed [VEL_W-1:0]     forward_velocity,
   input  logic signed [VEL_W-1:0]     side_velocity,
   input  logic signed [VEL_W-1:0]     turn_velocity,
   input  logic [FRAC_BITS-1:0]        deadzone_level,
   input  logic [FRAC_BITS:0]          filter_alpha,
   input  logic [DUTY_BITS-1:0]        max_duty,
   output logic signed [DUTY_BITS:0]   front_left_target,
   output logic signed [DUTY_BITS:0]   front_right_target,
   output logic signed [DUTY_BITS:0]   rear_left_target,
   output logic signed [DUTY_BITS:0]   rear_right_target
);

   localparam int CW = (FRAC_BITS + 1 > DUTY_BITS) ? FRAC_BITS + 1 : DUTY_BITS;
   localparam int VW = VEL_W + 2;          // wheel sums of three commands
   localparam int PW = CW + 1 + VW;
   localparam int AW = PW + 1;
   localparam int MW = VEL_W + 1;          // wheel magnitude
   localparam int DW = (FRAC_BITS + 1 > MW) ? FRAC_BITS + 1 : MW;
   localparam int ZW = (FRAC_BITS > MW) ? FRAC_BITS : MW;
   localparam int OW = DUTY_BITS + 1;

   logic signed [VEL_W-1:0] vel_ff [3];
   logic signed [VEL_W-1:0] filt_ff [3];
   logic signed [VEL_W-1:0] filt_in [3];
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic [MW-1:0]           max_ff, max_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DUTY_BITS-1:0]    quo_ff, quo_in;
   logic signed [OW-1:0]    tgt_ff [4];
   logic signed [OW-1:0]    tgt_in [4];

   logic [FRAC_BITS:0]      one_a, alpha_cl, alpha_rest;
   logic signed [VEL_W-1:0] vel_sel, filt_sel, dead_v;
   logic signed [VEL_W:0]   vel_ext;
   logic [ZW-1:0]           vel_mag;
   logic signed [VW-1:0]    f_ext, s_ext, t_ext;
   logic signed [VW-1:0]    wheel [4];
   logic signed [VW-1:0]    wheel_sel;
   logic [MW-1:0]           wheel_mag;
   logic [CW-1:0]           coef;
   logic signed [CW:0]      coef_s;
   logic signed [VW-1:0]    var_s;
   logic signed [PW-1:0]    prod;
   logic signed [AW-1:0]    acc_sum, acc_shr;
   logic [DW-1:0]           divisor, one_d;
   logic [DW:0]             rem_sh, rem_diff;
   logic                    rem_ge;
   logic [DUTY_BITS:0]      quo_ext;

   // Alpha above one acts as one.
   assign one_a      = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   assign alpha_cl   = (filter_alpha > one_a) ? one_a : filter_alpha;
   assign alpha_rest = one_a - alpha_cl;

   always_comb begin
      case (ctrl.idx)
         2'd0:    begin vel_sel = vel_ff[0]; filt_sel = filt_ff[0]; end
         2'd1:    begin vel_sel = vel_ff[1]; filt_sel = filt_ff[1]; end
         2'd2:    begin vel_sel = vel_ff[2]; filt_sel = filt_ff[2]; end
         default: begin vel_sel = '0;        filt_sel = '0;         end
      endcase
   end

   // A magnitude equal to the deadzone level passes unchanged.
   assign vel_ext = {vel_sel[VEL_W-1], vel_sel};
   assign vel_mag = vel_ext[VEL_W] ? ZW'(-vel_ext) : ZW'(vel_ext);
   assign dead_v  = (vel_mag < ZW'(deadzone_level)) ? '0 : vel_sel;

   assign f_ext    = VW'(filt_ff[0]);
   assign s_ext    = VW'(filt_ff[1]);
   assign t_ext    = VW'(filt_ff[2]);
   assign wheel[0] = f_ext + s_ext + t_ext;
   assign wheel[1] = f_ext - s_ext - t_ext;
   assign wheel[2] = f_ext - s_ext + t_ext;
   assign wheel[3] = f_ext + s_ext - t_ext;

   always_comb begin
      case (ctrl.idx)
         2'd0:    wheel_sel = wheel[0];
         2'd1:    wheel_sel = wheel[1];
         2'd2:    wheel_sel = wheel[2];
         default: wheel_sel = wheel[3];
      endcase
   end

   assign wheel_mag = wheel_sel[VW-1] ? MW'(-wheel_sel) : MW'(wheel_sel);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.op)
         OP_FILT_NEW: begin
            coef  = CW'(alpha_cl);
            var_s = VW'(dead_v);
         end
         OP_FILT_OLD: begin
            coef  = CW'(alpha_rest);
            var_s = VW'(filt_sel);
         end
         default: begin
            coef  = CW'(max_duty);
            var_s = VW'({1'b0, wheel_mag});
         end
      endcase
   end

   assign coef_s  = {1'b0, coef};
   assign prod    = PW'(coef_s) * PW'(var_s);
   assign acc_sum = acc_ff + AW'(prod);
   assign acc_shr = acc_sum >>> FRAC_BITS;

   // Divisor is the largest wheel magnitude, but never below one.
   assign one_d    = DW'(1) << FRAC_BITS;
   assign divisor  = (DW'(max_ff) > one_d) ? DW'(max_ff) : one_d;
   assign rem_sh   = {rem_ff, quo_ff[DUTY_BITS-1]};
   assign rem_ge   = (rem_sh >= {1'b0, divisor});
   assign rem_diff = rem_sh - {1'b0, divisor};

   always_comb begin
      filt_in = filt_ff;
      tgt_in  = tgt_ff;
      acc_in  = acc_ff;
      max_in  = max_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      quo_ext = '0;
      if (load) begin
         max_in = '0;
      end
      case (ctrl.op)
         OP_CLEAR: begin
            filt_in[0] = '0;
            filt_in[1] = '0;
            filt_in[2] = '0;
         end
         OP_FILT_NEW: begin
            acc_in = AW'(prod);
         end
         OP_FILT_OLD: begin
            case (ctrl.idx)
               2'd0:    filt_in[0] = acc_shr[VEL_W-1:0];
               2'd1:    filt_in[1] = acc_shr[VEL_W-1:0];
               default: filt_in[2] = acc_shr[VEL_W-1:0];
            endcase
         end
         OP_MAX: begin
            if (wheel_mag > max_ff) begin
               max_in = wheel_mag;
            end
         end
         OP_MUL: begin
            // The product is below divisor * 2^DUTY_BITS, so its upper part
            // already forms a valid partial remainder.
            rem_in = prod[DUTY_BITS +: DW];
            quo_in = prod[DUTY_BITS-1:0];
         end
         OP_DIV: begin
            rem_in  = rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            quo_in  = {quo_ff[DUTY_BITS-2:0], rem_ge};
            quo_ext = {1'b0, quo_in};
            if (ctrl.last) begin
               tgt_in[ctrl.idx] = wheel_sel[VW-1] ? -$signed(quo_ext) : $signed(quo_ext);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff[0] <= '0;
         filt_ff[1] <= '0;
         filt_ff[2] <= '0;
      end else begin
         filt_ff <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vel_ff[0] <= forward_velocity;
         vel_ff[1] <= side_velocity;
         vel_ff[2] <= turn_velocity;
      end
      acc_ff <= acc_in;
      max_ff <= max_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      tgt_ff <= tgt_in;
   end

   assign front_left_target  = tgt_ff[0];
   assign front_right_target = tgt_ff[1];
   assign rear_left_target   = tgt_ff[2];
   assign rear_right_target  = tgt_ff[3];

endmodule
